// ===== hw/rtl/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher unit.
// No dependencies; imported by every module of the block except rc4_ram.
`timescale 1ns / 1ps

package rc4_pkg;

   // Permutation store and byte geometry
   localparam int PERM_DEPTH  = 256;
   localparam int PERM_ADDR_W = 8;
   localparam int BYTE_W      = 8;

   // Key storage
   localparam int KEY_BYTES_MAX = 32;
   localparam int KEY_IDX_W     = 5;
   localparam int KEY_WORDS     = 4;
   localparam int KEY_WORD_W    = 64;
   localparam int KEY_VEC_W     = KEY_WORDS * KEY_WORD_W;
   localparam int KEY_LEN_W     = 6;

   // Register port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_WORD0  = 3'd0,
      REG_KEY_WORD1  = 3'd1,
      REG_KEY_WORD2  = 3'd2,
      REG_KEY_WORD3  = 3'd3,
      REG_KEY_LENGTH = 3'd4
   } csr_reg_type;

   // Sequencer states, one-hot
   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_FILL  = 12'b0000_0000_0010,
      ST_K_RDN = 12'b0000_0000_0100,
      ST_K_RDJ = 12'b0000_0000_1000,
      ST_K_WRN = 12'b0000_0001_0000,
      ST_K_WRJ = 12'b0000_0010_0000,
      ST_P_RDI = 12'b0000_0100_0000,
      ST_P_RDJ = 12'b0000_1000_0000,
      ST_P_WRI = 12'b0001_0000_0000,
      ST_P_WRJ = 12'b0010_0000_0000,
      ST_P_RDT = 12'b0100_0000_0000,
      ST_P_OUT = 12'b1000_0000_0000
   } ctrl_state_type;

   // Datapath commands, one step each
   typedef struct packed {
      logic load;       // capture the input byte
      logic clr_sched;  // clear counter, j and key index before scheduling
      logic fill_wr;    // S[n] = n, n++
      logic k_rd_n;     // read S[n]
      logic k_rd_j;     // j += S[n] + key, read S[j]
      logic k_wr_n;     // S[n] = S[j]
      logic k_wr_j;     // S[j] = old S[n], n++, key index++
      logic clr_idx;    // i = j = 0 at end of scheduling
      logic p_rd_i;     // i++, read S[i]
      logic p_rd_j;     // j += S[i], read S[j]
      logic p_wr_i;     // S[i] = S[j]
      logic p_wr_j;     // S[j] = old S[i]
      logic p_out;      // load result register
   } dp_cmd_type;

   typedef struct packed {
      logic n_last;     // sweep counter at last entry
      logic out_free;   // result register may be loaded this cycle
   } dp_status_type;

endpackage

// ===== hw/rtl/rc4_stream_cipher_unit.sv =====
// Top level of the RC4 stream cipher unit.
// Depends on rc4_pkg, rc4_csr, rc4_ctrl, rc4_dp and rc4_ram.
//
//   channel | direction | ports                                 | transfer when
//   --------+-----------+---------------------------------------+--------------------------
//   req     | in        | req_data_byte, req_message_start      | req_valid & req_ready
//   rsp     | out       | rsp_out_byte                          | rsp_valid & rsp_ready
//   csr     | in/out    | csr_paddr, csr_pwdata, csr_prdata     | psel & penable & pwrite
//
// One byte at a time: the next byte is taken only once the result of the previous one is
// loaded, an order set by the single read port of the 256-entry permutation RAM (read i,
// read j, two swap writes, read t, load result, idle).
// A message-start byte, and the first byte after reset, first runs key scheduling:
// an identity fill of all 256 entries, then a swap of S[n] and S[j] per entry, before its keystream step.
// Reset is synchronous and active high; the permutation RAM is not cleared.
// A result waiting in the output register holds the block only at its final step,
// so the next byte is taken as soon as the previous result is loaded.
`timescale 1ns / 1ps

module rc4_stream_cipher_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rc4_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           req_message_start,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rc4_pkg::BYTE_W-1:0]     rsp_out_byte,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rc4_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rc4_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rc4_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rc4_pkg::*;

   logic [KEY_VEC_W-1:0] key_vec;
   logic [KEY_LEN_W-1:0] key_length;
   dp_cmd_type           cmd;
   dp_status_type        status;

   rc4_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_vec     (key_vec),
      .key_length  (key_length)
   );

   rc4_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_message_start (req_message_start),
      .req_ready         (req_ready),
      .status            (status),
      .cmd               (cmd)
   );

   rc4_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data_byte (req_data_byte),
      .key_vec       (key_vec),
      .key_length    (key_length),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte)
   );

endmodule

// ===== hw/rtl/rc4_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the contents before a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rc4_csr.sv =====
// Key and key-length registers behind the APB-style register port.
// Depends on rc4_pkg.
`timescale 1ns / 1ps

module rc4_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rc4_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rc4_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [rc4_pkg::KEY_VEC_W-1:0]    key_vec,
   output logic [rc4_pkg::KEY_LEN_W-1:0]    key_length
);
   import rc4_pkg::*;

   logic [KEY_WORD_W-1:0] key_word_ff [KEY_WORDS];
   logic [KEY_WORD_W-1:0] key_word_in [KEY_WORDS];
   logic [KEY_LEN_W-1:0]  key_length_ff;
   logic [KEY_LEN_W-1:0]  key_length_in;
   csr_reg_type           reg_idx;
   logic                  wr_stb;

   // 8-byte register spacing
   assign reg_idx = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_stb  = csr_psel & csr_penable & csr_pwrite;

   // write decode; indexes past the list are dropped
   always_comb begin
      key_word_in   = key_word_ff;
      key_length_in = key_length_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_KEY_WORD0:  key_word_in[0] = csr_pwdata;
            REG_KEY_WORD1:  key_word_in[1] = csr_pwdata;
            REG_KEY_WORD2:  key_word_in[2] = csr_pwdata;
            REG_KEY_WORD3:  key_word_in[3] = csr_pwdata;
            REG_KEY_LENGTH: key_length_in = csr_pwdata[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < KEY_WORDS; w++) begin
            key_word_ff[w] <= '0;
         end
         key_length_ff <= KEY_LEN_W'(1);
      end else begin
         key_word_ff   <= key_word_in;
         key_length_ff <= key_length_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_KEY_WORD0:  csr_prdata = key_word_ff[0];
         REG_KEY_WORD1:  csr_prdata = key_word_ff[1];
         REG_KEY_WORD2:  csr_prdata = key_word_ff[2];
         REG_KEY_WORD3:  csr_prdata = key_word_ff[3];
         REG_KEY_LENGTH: csr_prdata = {{(CSR_DATA_W-KEY_LEN_W){1'b0}}, key_length_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign key_vec    = {key_word_ff[3], key_word_ff[2], key_word_ff[1], key_word_ff[0]};
   assign key_length = key_length_ff;

endmodule

// ===== hw/rtl/rc4_ctrl.sv =====
// Sequencer for the RC4 unit: key scheduling sweep and per-byte keystream steps.
// Depends on rc4_pkg; drives rc4_dp through command and status structs.
`timescale 1ns / 1ps

module rc4_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_message_start,
   output logic                   req_ready,
   input  rc4_pkg::dp_status_type status,
   output rc4_pkg::dp_cmd_type    cmd
);
   import rc4_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           keyed_ff;
   logic           keyed_in;

   always_comb begin
      state_in  = state_ff;
      keyed_in  = keyed_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // unkeyed permutation forces a reschedule
               if (req_message_start || !keyed_ff) begin
                  cmd.clr_sched = 1'b1;
                  state_in      = ST_FILL;
               end else begin
                  state_in = ST_P_RDI;
               end
            end
         end
         // identity fill, one entry a cycle
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (status.n_last) begin
               state_in = ST_K_RDN;
            end
         end
         // key scheduling swap per entry: read S[n], read S[j], write S[n], write S[j]
         ST_K_RDN: begin
            cmd.k_rd_n = 1'b1;
            state_in   = ST_K_RDJ;
         end
         ST_K_RDJ: begin
            cmd.k_rd_j = 1'b1;
            state_in   = ST_K_WRN;
         end
         ST_K_WRN: begin
            cmd.k_wr_n = 1'b1;
            state_in   = ST_K_WRJ;
         end
         ST_K_WRJ: begin
            cmd.k_wr_j = 1'b1;
            if (status.n_last) begin
               cmd.clr_idx = 1'b1;
               keyed_in    = 1'b1;
               state_in    = ST_P_RDI;
            end else begin
               state_in = ST_K_RDN;
            end
         end
         // keystream step
         ST_P_RDI: begin
            cmd.p_rd_i = 1'b1;
            state_in   = ST_P_RDJ;
         end
         ST_P_RDJ: begin
            cmd.p_rd_j = 1'b1;
            state_in   = ST_P_WRI;
         end
         ST_P_WRI: begin
            cmd.p_wr_i = 1'b1;
            state_in   = ST_P_WRJ;
         end
         ST_P_WRJ: begin
            cmd.p_wr_j = 1'b1;
            state_in   = ST_P_RDT;
         end
         ST_P_RDT: begin
            state_in = ST_P_OUT;
         end
         // hold until the result register is free
         ST_P_OUT: begin
            if (status.out_free) begin
               cmd.p_out = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         keyed_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         keyed_ff <= keyed_in;
      end
   end

endmodule

// ===== hw/rtl/rc4_dp.sv =====
// RC4 datapath: permutation RAM, indices, swap holding registers, result register.
// Depends on rc4_pkg and rc4_ram; steered by rc4_ctrl.
`timescale 1ns / 1ps

module rc4_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rc4_pkg::dp_cmd_type           cmd,
   output rc4_pkg::dp_status_type        status,
   input  logic [rc4_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [rc4_pkg::KEY_VEC_W-1:0] key_vec,
   input  logic [rc4_pkg::KEY_LEN_W-1:0] key_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rc4_pkg::BYTE_W-1:0]    rsp_out_byte
);
   import rc4_pkg::*;

   logic [PERM_ADDR_W-1:0] n_ff, n_in;
   logic [KEY_IDX_W-1:0]   kidx_ff, kidx_in;
   logic [PERM_ADDR_W-1:0] i_ff, i_in;
   logic [PERM_ADDR_W-1:0] j_ff, j_in;
   logic [BYTE_W-1:0]      si_ff, si_in;
   logic [BYTE_W-1:0]      sj_ff, sj_in;
   logic [BYTE_W-1:0]      data_ff, data_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]      out_byte_ff, out_byte_in;

   logic                   ram_we;
   logic [PERM_ADDR_W-1:0] ram_waddr;
   logic [BYTE_W-1:0]      ram_wdata;
   logic [PERM_ADDR_W-1:0] ram_raddr;
   logic [BYTE_W-1:0]      ram_rdata;

   logic [KEY_IDX_W-1:0]   kidx_last;
   logic [BYTE_W-1:0]      key_byte;
   logic [PERM_ADDR_W-1:0] j_ksa;
   logic [PERM_ADDR_W-1:0] j_prga;
   logic [PERM_ADDR_W-1:0] i_next;

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PERM_DEPTH)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // effective key length: zero counts as one, saturate at the key size
   always_comb begin
      if (key_length == '0) begin
         kidx_last = '0;
      end else if (key_length > KEY_LEN_W'(KEY_BYTES_MAX)) begin
         kidx_last = KEY_IDX_W'(KEY_BYTES_MAX - 1);
      end else begin
         kidx_last = KEY_IDX_W'(key_length - 1'b1);
      end
   end

   assign key_byte = key_vec[kidx_ff*BYTE_W +: BYTE_W];
   assign j_ksa    = j_ff + ram_rdata + key_byte;
   assign j_prga   = j_ff + ram_rdata;
   assign i_next   = i_ff + 1'b1;

   // step logic
   always_comb begin
      n_in         = n_ff;
      kidx_in      = kidx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      data_in      = data_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_byte_in  = out_byte_ff;
      ram_we       = 1'b0;
      ram_waddr    = n_ff;
      ram_wdata    = n_ff;
      // keystream address stays put while the result waits
      ram_raddr    = si_ff + sj_ff;

      if (cmd.load) begin
         data_in = req_data_byte;
      end
      if (cmd.clr_sched) begin
         n_in    = '0;
         j_in    = '0;
         kidx_in = '0;
      end
      if (cmd.fill_wr) begin
         ram_we = 1'b1;
         n_in   = n_ff + 1'b1;
      end
      if (cmd.k_rd_n) begin
         ram_raddr = n_ff;
      end
      if (cmd.k_rd_j) begin
         si_in     = ram_rdata;
         j_in      = j_ksa;
         ram_raddr = j_ksa;
      end
      if (cmd.k_wr_n) begin
         sj_in     = ram_rdata;
         ram_we    = 1'b1;
         ram_waddr = n_ff;
         ram_wdata = ram_rdata;
      end
      if (cmd.k_wr_j) begin
         ram_we    = 1'b1;
         ram_waddr = j_ff;
         ram_wdata = si_ff;
         n_in      = n_ff + 1'b1;
         kidx_in   = (kidx_ff == kidx_last) ? '0 : kidx_ff + 1'b1;
      end
      if (cmd.clr_idx) begin
         i_in = '0;
         j_in = '0;
      end
      if (cmd.p_rd_i) begin
         i_in      = i_next;
         ram_raddr = i_next;
      end
      if (cmd.p_rd_j) begin
         si_in     = ram_rdata;
         j_in      = j_prga;
         ram_raddr = j_prga;
      end
      if (cmd.p_wr_i) begin
         sj_in     = ram_rdata;
         ram_we    = 1'b1;
         ram_waddr = i_ff;
         ram_wdata = ram_rdata;
      end
      if (cmd.p_wr_j) begin
         ram_we    = 1'b1;
         ram_waddr = j_ff;
         ram_wdata = si_ff;
      end
      if (cmd.p_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = data_ff ^ ram_rdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      kidx_ff     <= kidx_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      data_ff     <= data_in;
      out_byte_ff <= out_byte_in;
   end

   // indices and result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.n_last   = (n_ff == PERM_ADDR_W'(PERM_DEPTH - 1));
   assign status.out_free = ~out_valid_ff | rsp_ready;
   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;

endmodule

// ===== hw/rtl/rc4_checker.sv =====
// Port-level checks for the RC4 stream cipher unit, bound to the top level.
// Depends on rc4_pkg and rc4_stream_cipher_unit.
`timescale 1ns / 1ps

module rc4_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [rc4_pkg::BYTE_W-1:0]     req_data_byte,
   input logic                           req_message_start,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rc4_pkg::BYTE_W-1:0]     rsp_out_byte,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pwrite,
   input logic [rc4_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [rc4_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [rc4_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                           csr_pready
);
   import rc4_pkg::*;

   // a waiting input transfer keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data_byte)
                                  && $stable(req_message_start))
      else $error("rc4: input payload changed while waiting");

   // a stalled result holds its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("rc4: result changed while stalled");

   // one byte in flight: the unit stays busy after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##1 !req_ready ##1 !req_ready)
      else $error("rc4: input taken again too soon");

   // a result appears only as the keystream step finishes and the unit goes idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("rc4: result raised while busy");

   // key word 0 reads back what was just written
   a_key0_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == 6'd0)
      ##1 (csr_psel && !csr_pwrite && csr_paddr == 6'd0)
      |-> csr_prdata == $past(csr_pwdata))
      else $error("rc4: key word 0 read-back mismatch");

endmodule

bind rc4_stream_cipher_unit rc4_checker u_checker (.*);
